// File: design/dktq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the dual key task queue
// no dependencies; imported by every design file

package dktq_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int PRIO_W = 8;
   localparam int HOURS_W = 5;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;
   localparam int TIME_W = HOURS_W + MINUTES_W + SECONDS_W;
   localparam int TAG_W = 16;
   localparam int OUT_COUNT_W = 5;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_EXEC   = 2'd1,
      ACT_NEXT   = 2'd2,
      ACT_CHANGE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY
   } state_type;

   // time packed as hours, minutes, seconds so a plain compare is lexicographic
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] tm;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } cand_type;

   // command broadcast to every cell
   typedef struct packed {
      action_type        action;
      logic              by_time;
      logic [PRIO_W-1:0] new_prio;
      logic [TIME_W-1:0] new_time;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] old_prio;
      logic [TIME_W-1:0] old_time;
      logic              apply;
   } cmd_type;

endpackage

// File: design/dual_key_task_queue.sv
`timescale 1ns / 1ps
// dual key task queue: a row of CAPACITY cells; the best candidate and the
// match count ripple one cell per cycle along the row
// the rsp_valid beat is registered after the cell-to-cell scan and the apply state
// a request is taken only while idle, so the next one waits until this one is done
// the receiver cannot stall; every result is a single-cycle beat
// synchronous reset empties the table and returns to idle

module dual_key_task_queue #(
   parameter int CAPACITY = dktq_pkg::DEF_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic                               req_by_time,
   input  logic [dktq_pkg::PRIO_W-1:0]        req_priority_req,
   input  logic [dktq_pkg::HOURS_W-1:0]       req_hours,
   input  logic [dktq_pkg::MINUTES_W-1:0]     req_minutes,
   input  logic [dktq_pkg::SECONDS_W-1:0]     req_seconds,
   input  logic [dktq_pkg::TAG_W-1:0]         req_tag,
   input  logic [dktq_pkg::PRIO_W-1:0]        req_old_priority,
   input  logic [dktq_pkg::HOURS_W-1:0]       req_old_hours,
   input  logic [dktq_pkg::MINUTES_W-1:0]     req_old_minutes,
   input  logic [dktq_pkg::SECONDS_W-1:0]     req_old_seconds,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [dktq_pkg::PRIO_W-1:0]        rsp_out_priority,
   output logic [dktq_pkg::HOURS_W-1:0]       rsp_out_hours,
   output logic [dktq_pkg::MINUTES_W-1:0]     rsp_out_minutes,
   output logic [dktq_pkg::SECONDS_W-1:0]     rsp_out_seconds,
   output logic [dktq_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic [dktq_pkg::OUT_COUNT_W-1:0]   rsp_occupancy,
   output logic [dktq_pkg::OUT_COUNT_W-1:0]   rsp_changed_count
);
   import dktq_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type     state_ff, state_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [CW-1:0] count_ff, count_in;
   cmd_type       req_ff, req_in;
   cmd_type       cmd;
   logic          accept;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   entry_type     out_ff, out_in;
   logic [CW-1:0] changed_ff, changed_in;

   entry_type     entries [CAPACITY];
   cand_type      cands [CAPACITY];
   logic [IW-1:0] cand_idx [CAPACITY];
   logic [CW-1:0] cand_cnt [CAPACITY];

   cand_type      best;

   assign accept = start && (state_ff == FSM_IDLE);
   assign busy   = state_ff != FSM_IDLE;

   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.action   = action_type'(req_action);
         req_in.by_time  = req_by_time;
         req_in.new_prio = req_priority_req;
         req_in.new_time = {req_hours, req_minutes, req_seconds};
         req_in.tag      = req_tag;
         req_in.old_prio = req_old_priority;
         req_in.old_time = {req_old_hours, req_old_minutes, req_old_seconds};
      end
      req_in.apply = 1'b0;
      cmd = req_ff;
      cmd.apply = state_ff == FSM_APPLY;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         cand_type      p_cand;
         logic [IW-1:0] p_idx;
         logic [CW-1:0] p_cnt;
         entry_type     n_entry;
         if (gi == 0) begin : g_head
            assign p_cand = '0;
            assign p_idx  = '0;
            assign p_cnt  = '0;
         end else begin : g_body
            assign p_cand = cands[gi-1];
            assign p_idx  = cand_idx[gi-1];
            assign p_cnt  = cand_cnt[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign n_entry = entries[gi];
         end else begin : g_mid
            assign n_entry = entries[gi+1];
         end
         dktq_cell #(
            .CAPACITY(CAPACITY),
            .INDEX(gi),
            .IW(IW),
            .CW(CW)
         ) u_cell (
            .clock(clock),
            .cmd(cmd),
            .count(count_ff),
            .best_idx(cand_idx[CAPACITY-1]),
            .prev_cand(p_cand),
            .prev_idx(p_idx),
            .prev_cnt(p_cnt),
            .cand(cands[gi]),
            .cand_idx(cand_idx[gi]),
            .cand_cnt(cand_cnt[gi]),
            .next_entry(n_entry),
            .entry(entries[gi])
         );
      end
   endgenerate

   assign best = cands[CAPACITY-1];

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      out_in       = out_ff;
      changed_in   = changed_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_SCAN;
               scan_in  = '0;
            end
         end
         FSM_SCAN: begin
            // the tail cell holds the answer once every cell has been visited
            if (scan_ff == IW'(CAPACITY - 1)) begin
               state_in = FSM_APPLY;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         FSM_APPLY: begin
            state_in     = FSM_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            out_in       = '0;
            changed_in   = '0;
            case (req_ff.action)
               ACT_ADD: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               ACT_EXEC, ACT_NEXT: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     out_in = best.entry;
                     if (req_ff.action == ACT_EXEC) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               ACT_CHANGE: begin
                  changed_in = cand_cnt[CAPACITY-1];
                  if (cand_cnt[CAPACITY-1] == '0) begin
                     status_in = ST_NOMATCH;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      req_ff     <= req_in;
      status_ff  <= status_in;
      out_ff     <= out_in;
      changed_ff <= changed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_priority  = out_ff.prio;
   assign rsp_out_hours     = out_ff.tm[TIME_W-1 -: HOURS_W];
   assign rsp_out_minutes   = out_ff.tm[SECONDS_W +: MINUTES_W];
   assign rsp_out_seconds   = out_ff.tm[SECONDS_W-1:0];
   assign rsp_out_tag       = out_ff.tag;
   assign rsp_occupancy     = OUT_COUNT_W'(count_ff);
   assign rsp_changed_count = OUT_COUNT_W'(changed_ff);

endmodule

// File: design/dktq_cell.sv
`timescale 1ns / 1ps
// one table slot: holds an entry and passes the running best candidate
// and match count on to its right neighbor; depends on dktq_pkg

module dktq_cell #(
   parameter int CAPACITY = dktq_pkg::DEF_CAPACITY,
   parameter int INDEX = 0,
   parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CW = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  dktq_pkg::cmd_type   cmd,
   input  logic [CW-1:0]       count,
   input  logic [IW-1:0]       best_idx,
   input  dktq_pkg::cand_type  prev_cand,
   input  logic [IW-1:0]       prev_idx,
   input  logic [CW-1:0]       prev_cnt,
   output dktq_pkg::cand_type  cand,
   output logic [IW-1:0]       cand_idx,
   output logic [CW-1:0]       cand_cnt,
   input  dktq_pkg::entry_type next_entry,
   output dktq_pkg::entry_type entry
);
   import dktq_pkg::*;

   entry_type     entry_ff, entry_in;
   cand_type      cand_ff, cand_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          own_valid, match, take_own, better;

   always_comb begin
      own_valid = CW'(INDEX) < count;
      if (cmd.by_time) begin
         match  = entry_ff.tm == cmd.old_time;
         better = entry_ff.tm < prev_cand.entry.tm;
      end else begin
         match  = entry_ff.prio == cmd.old_prio;
         better = entry_ff.prio > prev_cand.entry.prio;
      end
      match = match && own_valid;
      // ties keep the earlier candidate
      take_own = own_valid && (!prev_cand.valid || better);
      if (take_own) begin
         cand_in = {1'b1, entry_ff};
         idx_in  = IW'(INDEX);
      end else begin
         cand_in = prev_cand;
         idx_in  = prev_idx;
      end
      cnt_in = prev_cnt + CW'(match);

      entry_in = entry_ff;
      if (cmd.apply) begin
         case (cmd.action)
            ACT_ADD: begin
               if (CW'(INDEX) == count) begin
                  entry_in.prio = cmd.new_prio;
                  entry_in.tm   = cmd.new_time;
                  entry_in.tag  = cmd.tag;
               end
            end
            ACT_EXEC: begin
               // close the gap left by the removed entry
               if (IW'(INDEX) >= best_idx && (CW'(INDEX) + CW'(1)) < count) begin
                  entry_in = next_entry;
               end
            end
            ACT_CHANGE: begin
               if (match) begin
                  if (cmd.by_time) begin
                     entry_in.tm = cmd.new_time;
                  end else begin
                     entry_in.prio = cmd.new_prio;
                  end
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      cand_ff  <= cand_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
   end

   assign entry    = entry_ff;
   assign cand     = cand_ff;
   assign cand_idx = idx_ff;
   assign cand_cnt = cnt_ff;

endmodule

// File: design/dktq_checker.sv
`timescale 1ns / 1ps
// port-level checks for the dual key task queue, bound to the top level
// depends on dktq_pkg and dual_key_task_queue

module dktq_checker #(
   parameter int CAPACITY = dktq_pkg::DEF_CAPACITY
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [1:0]                          rsp_status,
   input logic [dktq_pkg::OUT_COUNT_W-1:0]    rsp_occupancy,
   input logic [dktq_pkg::OUT_COUNT_W-1:0]    rsp_changed_count
);
   import dktq_pkg::*;

   // an accepted beat keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat lasted more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOMATCH |-> rsp_changed_count == '0)
      else $error("no-match result with nonzero changed count");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == OUT_COUNT_W'(CAPACITY))
      else $error("full status without a full table");

endmodule

bind dual_key_task_queue dktq_checker #(.CAPACITY(CAPACITY)) u_dktq_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_status(rsp_status),
   .rsp_occupancy(rsp_occupancy),
   .rsp_changed_count(rsp_changed_count)
);

// File: dv/dual_key_task_queue_tb.sv
`timescale 1ns / 1ps
// testbench for dual_key_task_queue: directed and random add, exec, next and change beats
// keeps a shadow copy of the task table to predict every result; needs design/dktq_pkg.sv

module dual_key_task_queue_tb;
   import dktq_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int DUT_LATENCY = CAPACITY + 2;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      action_type           action;
      logic                 by_time;
      logic [PRIO_W-1:0]    prio;
      logic [HOURS_W-1:0]   hours;
      logic [MINUTES_W-1:0] minutes;
      logic [SECONDS_W-1:0] seconds;
      logic [TAG_W-1:0]     tag;
      logic [PRIO_W-1:0]    old_prio;
      logic [HOURS_W-1:0]   old_hours;
      logic [MINUTES_W-1:0] old_minutes;
      logic [SECONDS_W-1:0] old_seconds;
   } queue_cmd_type;

   typedef struct {
      status_type             status;
      logic [PRIO_W-1:0]      prio;
      logic [HOURS_W-1:0]     hours;
      logic [MINUTES_W-1:0]   minutes;
      logic [SECONDS_W-1:0]   seconds;
      logic [TAG_W-1:0]       tag;
      logic [OUT_COUNT_W-1:0] occupancy;
      logic [OUT_COUNT_W-1:0] changed;
   } queue_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_action = '0;
   logic                   req_by_time = 1'b0;
   logic [PRIO_W-1:0]      req_priority_req = '0;
   logic [HOURS_W-1:0]     req_hours = '0;
   logic [MINUTES_W-1:0]   req_minutes = '0;
   logic [SECONDS_W-1:0]   req_seconds = '0;
   logic [TAG_W-1:0]       req_tag = '0;
   logic [PRIO_W-1:0]      req_old_priority = '0;
   logic [HOURS_W-1:0]     req_old_hours = '0;
   logic [MINUTES_W-1:0]   req_old_minutes = '0;
   logic [SECONDS_W-1:0]   req_old_seconds = '0;
   logic                   rsp_valid;
   logic [1:0]             rsp_status;
   logic [PRIO_W-1:0]      rsp_out_priority;
   logic [HOURS_W-1:0]     rsp_out_hours;
   logic [MINUTES_W-1:0]   rsp_out_minutes;
   logic [SECONDS_W-1:0]   rsp_out_seconds;
   logic [TAG_W-1:0]       rsp_out_tag;
   logic [OUT_COUNT_W-1:0] rsp_occupancy;
   logic [OUT_COUNT_W-1:0] rsp_changed_count;

   // shadow copy of the task table, insertion order kept
   logic [PRIO_W-1:0] shadow_prio [CAPACITY];
   logic [TIME_W-1:0] shadow_time [CAPACITY];
   logic [TAG_W-1:0]  shadow_tag [CAPACITY];
   int                shadow_count = 0;

   queue_outcome_type pending_outcomes[$];
   queue_outcome_type due_outcome;
   int error_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int cycle_count = 0;

   dual_key_task_queue #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_by_time(req_by_time),
      .req_priority_req(req_priority_req),
      .req_hours(req_hours),
      .req_minutes(req_minutes),
      .req_seconds(req_seconds),
      .req_tag(req_tag),
      .req_old_priority(req_old_priority),
      .req_old_hours(req_old_hours),
      .req_old_minutes(req_old_minutes),
      .req_old_seconds(req_old_seconds),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_priority(rsp_out_priority),
      .rsp_out_hours(rsp_out_hours),
      .rsp_out_minutes(rsp_out_minutes),
      .rsp_out_seconds(rsp_out_seconds),
      .rsp_out_tag(rsp_out_tag),
      .rsp_occupancy(rsp_occupancy),
      .rsp_changed_count(rsp_changed_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one command to the shadow table and returns the beat it should produce
   function automatic queue_outcome_type serve_shadow_table(input queue_cmd_type c);
      queue_outcome_type o;
      int best;
      int hits;
      logic [TIME_W-1:0] old_t;
      logic [TIME_W-1:0] new_t;
      o.status = ST_OK;
      o.prio = '0;
      o.hours = '0;
      o.minutes = '0;
      o.seconds = '0;
      o.tag = '0;
      hits = 0;
      old_t = {c.old_hours, c.old_minutes, c.old_seconds};
      new_t = {c.hours, c.minutes, c.seconds};
      case (c.action)
         ACT_ADD: begin
            if (shadow_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               shadow_prio[shadow_count] = c.prio;
               shadow_time[shadow_count] = new_t;
               shadow_tag[shadow_count] = c.tag;
               shadow_count++;
            end
         end
         ACT_EXEC, ACT_NEXT: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               best = 0;
               // strict compares keep the oldest entry on ties
               for (int i = 1; i < shadow_count; i++) begin
                  if (c.by_time) begin
                     if (shadow_time[i] < shadow_time[best]) best = i;
                  end else begin
                     if (shadow_prio[i] > shadow_prio[best]) best = i;
                  end
               end
               o.prio = shadow_prio[best];
               {o.hours, o.minutes, o.seconds} = shadow_time[best];
               o.tag = shadow_tag[best];
               if (c.action == ACT_EXEC) begin
                  for (int i = best; i < shadow_count - 1; i++) begin
                     shadow_prio[i] = shadow_prio[i + 1];
                     shadow_time[i] = shadow_time[i + 1];
                     shadow_tag[i] = shadow_tag[i + 1];
                  end
                  shadow_count--;
               end
            end
         end
         default: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (c.by_time) begin
                  if (shadow_time[i] == old_t) begin
                     shadow_time[i] = new_t;
                     hits++;
                  end
               end else begin
                  if (shadow_prio[i] == c.old_prio) begin
                     shadow_prio[i] = c.prio;
                     hits++;
                  end
               end
            end
            if (hits == 0) o.status = ST_NOMATCH;
         end
      endcase
      o.occupancy = OUT_COUNT_W'(shadow_count);
      o.changed = OUT_COUNT_W'(hits);
      return o;
   endfunction

   function automatic queue_cmd_type make_cmd(
      input action_type a, input logic bt, input logic [PRIO_W-1:0] p,
      input logic [HOURS_W-1:0] h, input logic [MINUTES_W-1:0] m,
      input logic [SECONDS_W-1:0] s, input logic [TAG_W-1:0] tg,
      input logic [PRIO_W-1:0] op, input logic [HOURS_W-1:0] oh,
      input logic [MINUTES_W-1:0] om, input logic [SECONDS_W-1:0] os);
      queue_cmd_type c;
      c.action = a;
      c.by_time = bt;
      c.prio = p;
      c.hours = h;
      c.minutes = m;
      c.seconds = s;
      c.tag = tg;
      c.old_prio = op;
      c.old_hours = oh;
      c.old_minutes = om;
      c.old_seconds = os;
      return c;
   endfunction

   // keys come mostly from a few values so ties and change matches are common
   function automatic queue_cmd_type random_cmd(input int add_pct);
      queue_cmd_type c;
      int pick;
      int r;
      c.by_time = 1'($urandom_range(0, 1));
      c.prio = PRIO_W'($urandom);
      c.hours = HOURS_W'($urandom);
      c.minutes = MINUTES_W'($urandom);
      c.seconds = SECONDS_W'($urandom);
      c.tag = TAG_W'($urandom);
      c.old_prio = PRIO_W'($urandom);
      c.old_hours = HOURS_W'($urandom);
      c.old_minutes = MINUTES_W'($urandom);
      c.old_seconds = SECONDS_W'($urandom);
      if ($urandom_range(0, 99) < 70) c.prio = PRIO_W'($urandom_range(0, 5) * 51);
      if ($urandom_range(0, 99) < 70) begin
         c.hours = HOURS_W'($urandom_range(0, 2) * 11);
         c.minutes = MINUTES_W'($urandom_range(0, 2) * 29);
         c.seconds = SECONDS_W'($urandom_range(0, 2) * 29);
      end
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
         c.action = ACT_ADD;
      end else begin
         case ($urandom_range(0, 3))
            0, 1: c.action = ACT_EXEC;
            2: c.action = ACT_NEXT;
            default: c.action = ACT_CHANGE;
         endcase
      end
      if (c.action == ACT_CHANGE && shadow_count > 0 && $urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, shadow_count - 1);
         c.old_prio = shadow_prio[pick];
         {c.old_hours, c.old_minutes, c.old_seconds} = shadow_time[pick];
      end
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(8, 45);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d on %s: got %0d, expected %0d",
               cycle_count, field, got, want);
      error_count++;
   endtask

   // drive one command and hold it until the block takes the beat
   task automatic send_cmd(input queue_cmd_type c, input int gap);
      start <= 1'b1;
      req_action <= c.action;
      req_by_time <= c.by_time;
      req_priority_req <= c.prio;
      req_hours <= c.hours;
      req_minutes <= c.minutes;
      req_seconds <= c.seconds;
      req_tag <= c.tag;
      req_old_priority <= c.old_prio;
      req_old_hours <= c.old_hours;
      req_old_minutes <= c.old_minutes;
      req_old_seconds <= c.old_seconds;
      do @(posedge clock); while (busy !== 1'b0);
      pending_outcomes.push_back(serve_shadow_table(c));
      sent_count++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_cmd(make_cmd(ACT_EXEC, 1'b0, 8'd0, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_NEXT, 1'b1, 8'd255, 5'd31, 6'd63, 6'd63, 16'hFFFF,
                        8'd255, 5'd31, 6'd63, 6'd63), pick_gap());
      send_cmd(make_cmd(ACT_CHANGE, 1'b0, 8'd9, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_CHANGE, 1'b1, 8'd0, 5'd1, 6'd1, 6'd1, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
   endtask

   // ties on both keys, out of range times, change hits and misses
   task automatic test_key_extremes();
      send_cmd(make_cmd(ACT_ADD, 1'b0, 8'd255, 5'd0, 6'd0, 6'd0, 16'hFFFF,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_ADD, 1'b1, 8'd0, 5'd23, 6'd59, 6'd59, 16'h0000,
                        8'd255, 5'd31, 6'd63, 6'd63), pick_gap());
      send_cmd(make_cmd(ACT_ADD, 1'b0, 8'd255, 5'd31, 6'd63, 6'd63, 16'h1234,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_ADD, 1'b1, 8'd7, 5'd0, 6'd0, 6'd0, 16'h5A5A,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_NEXT, 1'b0, 8'd0, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_NEXT, 1'b1, 8'd0, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_CHANGE, 1'b0, 8'd200, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd255, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_CHANGE, 1'b1, 8'd0, 5'd5, 6'd5, 6'd5, 16'd0,
                        8'd0, 5'd1, 6'd2, 6'd3), pick_gap());
      send_cmd(make_cmd(ACT_CHANGE, 1'b1, 8'd0, 5'd24, 6'd60, 6'd60, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_EXEC, 1'b0, 8'd0, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
      send_cmd(make_cmd(ACT_EXEC, 1'b1, 8'd0, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
   endtask

   task automatic test_full_table();
      queue_cmd_type c;
      while (shadow_count < CAPACITY) begin
         c = random_cmd(100);
         send_cmd(c, pick_gap());
      end
      c = random_cmd(100);
      send_cmd(c, pick_gap());
      send_cmd(make_cmd(ACT_ADD, 1'b1, 8'd255, 5'd31, 6'd63, 6'd63, 16'hFFFF,
                        8'd255, 5'd31, 6'd63, 6'd63), pick_gap());
      send_cmd(make_cmd(ACT_NEXT, 1'b1, 8'd0, 5'd0, 6'd0, 6'd0, 16'd0,
                        8'd0, 5'd0, 6'd0, 6'd0), pick_gap());
   endtask

   // phases lean toward filling, draining or a mix so both table limits are hit often
   task automatic test_random_traffic(input int count);
      queue_cmd_type c;
      int add_pct;
      int gap;
      for (int n = 0; n < count; n++) begin
         case ((n / 150) % 3)
            0: add_pct = 70;
            1: add_pct = 20;
            default: add_pct = 40;
         endcase
         c = random_cmd(add_pct);
         gap = ((n / 100) % 5 == 2) ? 0 : pick_gap();
         send_cmd(c, gap);
         if (n == count / 2) hold_until_drained();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("beat with nothing due", 32'(rsp_status), 0);
         end else begin
            due_outcome = pending_outcomes.pop_front();
            checked_count++;
            if (rsp_status !== due_outcome.status)
               report_mismatch("status", 32'(rsp_status), 32'(due_outcome.status));
            if (rsp_out_priority !== due_outcome.prio)
               report_mismatch("out_priority", 32'(rsp_out_priority),
                               32'(due_outcome.prio));
            if (rsp_out_hours !== due_outcome.hours)
               report_mismatch("out_hours", 32'(rsp_out_hours), 32'(due_outcome.hours));
            if (rsp_out_minutes !== due_outcome.minutes)
               report_mismatch("out_minutes", 32'(rsp_out_minutes),
                               32'(due_outcome.minutes));
            if (rsp_out_seconds !== due_outcome.seconds)
               report_mismatch("out_seconds", 32'(rsp_out_seconds),
                               32'(due_outcome.seconds));
            if (rsp_out_tag !== due_outcome.tag)
               report_mismatch("out_tag", 32'(rsp_out_tag), 32'(due_outcome.tag));
            if (rsp_occupancy !== due_outcome.occupancy)
               report_mismatch("occupancy", 32'(rsp_occupancy),
                               32'(due_outcome.occupancy));
            if (rsp_changed_count !== due_outcome.changed)
               report_mismatch("changed_count", 32'(rsp_changed_count),
                               32'(due_outcome.changed));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      shadow_count = 0;
      test_empty_table();
      test_key_extremes();
      hold_until_drained();
      test_full_table();
      test_random_traffic(RANDOM_ITEMS);
      hold_until_drained();
      repeat (DUT_LATENCY + 4) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $display("%0d results never arrived", pending_outcomes.size());
         error_count++;
      end
      $display("ran %0d beats of add, exec, next and change on both keys,", sent_count);
      $display("empty and full table included; %0d results checked, %0d mismatches",
               checked_count, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
design/dktq_pkg.sv
design/dktq_cell.sv
design/dual_key_task_queue.sv
design/dktq_checker.sv
dv/dual_key_task_queue_tb.sv
